>>> rtl/last_lines_ring_buffer_assert.svh
// assertion macros used by the ring buffer datapath
`ifndef LAST_LINES_RING_BUFFER_ASSERT_SVH
`define LAST_LINES_RING_BUFFER_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define LLRB_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define LLRB_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/llrb_pkg.sv
package llrb_pkg;

    localparam int MAX_LINES   = 16;
    localparam int SLOT_W      = $clog2(MAX_LINES);
    localparam int CNT_W       = 5;
    localparam int LINE_MAX    = 2047;
    localparam int POS_W       = $clog2(LINE_MAX + 2);
    localparam int OFS_W       = $clog2(LINE_MAX + 1);
    localparam int ADDR_W      = SLOT_W + OFS_W;
    localparam int STORE_DEPTH = MAX_LINES * (2 ** OFS_W);

    localparam logic [7:0]       NEWLINE_CODE   = 8'd10;
    localparam logic [CNT_W-1:0] DEF_LINE_COUNT = 5'd10;

    // input beat operation codes
    typedef enum logic [1:0] {
        OP_DATA = 2'd0,
        OP_END  = 2'd1,
        OP_READ = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    // controller to datapath commands
    typedef struct packed {
        logic byte_wr;
        logic end_in;
        logic skip_step;
        logic fetch;
        logic load_null;
        logic load_byte;
    } dp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic reading;
        logic exhausted;
        logic len_zero;
        logic offset_past;
        logic out_free;
    } dp_sts_t;

    // ring size in use: zero means one, large values saturate
    function automatic logic [CNT_W-1:0] count_eff(input logic [CNT_W-1:0] lc);
        logic [CNT_W-1:0] c;
        c = lc;
        if (lc == '0)
        begin
            c = CNT_W'(1);
        end
        else if (lc > CNT_W'(MAX_LINES))
        begin
            c = CNT_W'(MAX_LINES);
        end
        return c;
    endfunction

    // step a slot pointer round the ring
    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s,
                                                    input logic [CNT_W-1:0] ce);
        logic [CNT_W-1:0] n;
        logic [SLOT_W-1:0] r;
        n = {1'b0, s} + CNT_W'(1);
        r = n[SLOT_W-1:0];
        if (n >= ce || n >= CNT_W'(MAX_LINES))
        begin
            r = '0;
        end
        return r;
    endfunction

endpackage

>>> rtl/llrb_ctrl.sv
module llrb_ctrl
    import llrb_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  op_t     operation,
    input  dp_sts_t sts,
    output dp_cmd_t cmd
);

    typedef enum logic [7:0] {
        S_IDLE      = 8'b0000_0001,
        S_RD_CHECK  = 8'b0000_0010,
        S_SKIP_END  = 8'b0000_0100,
        S_SKIP_PRE  = 8'b0000_1000,
        S_FETCH     = 8'b0001_0000,
        S_SKIP_POST = 8'b0010_0000,
        S_EMIT_NULL = 8'b0100_0000,
        S_EMIT_BYTE = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;
    logic   skip_more;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    // another empty slot to pass over
    assign skip_more = !sts.exhausted && sts.len_zero;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (operation)
                        OP_DATA:
                        begin
                            cmd.byte_wr = !sts.reading;
                        end
                        OP_END:
                        begin
                            if (!sts.reading)
                            begin
                                cmd.end_in = 1'b1;
                                state_next = S_SKIP_END;
                            end
                        end
                        OP_READ:
                        begin
                            state_next = S_RD_CHECK;
                        end
                        OP_NONE:
                        begin
                            state_next = S_IDLE;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_RD_CHECK:
            begin
                if (!sts.reading || sts.exhausted)
                begin
                    state_next = S_EMIT_NULL;
                end
                else if (sts.offset_past)
                begin
                    state_next = S_SKIP_PRE;
                end
                else
                begin
                    state_next = S_FETCH;
                end
            end
            S_SKIP_END:
            begin
                if (skip_more)
                begin
                    cmd.skip_step = 1'b1;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_SKIP_PRE:
            begin
                if (skip_more)
                begin
                    cmd.skip_step = 1'b1;
                end
                else if (sts.exhausted)
                begin
                    state_next = S_EMIT_NULL;
                end
                else
                begin
                    state_next = S_FETCH;
                end
            end
            S_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = S_SKIP_POST;
            end
            S_SKIP_POST:
            begin
                if (skip_more)
                begin
                    cmd.skip_step = 1'b1;
                end
                else
                begin
                    state_next = S_EMIT_BYTE;
                end
            end
            S_EMIT_NULL:
            begin
                if (sts.out_free)
                begin
                    cmd.load_null = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_EMIT_BYTE:
            begin
                if (sts.out_free)
                begin
                    cmd.load_byte = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> rtl/llrb_datapath.sv
`include "last_lines_ring_buffer_assert.svh"

module llrb_datapath
    import llrb_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  dp_cmd_t          cmd,
    output dp_sts_t          sts,
    input  logic [7:0]       data_byte,
    input  logic             cfg_valid,
    input  logic [CNT_W-1:0] cfg_data,
    input  logic             out_ready,
    output logic             out_valid,
    output logic [7:0]       out_byte,
    output logic             out_byte_valid,
    output logic             out_last
);

    logic [CNT_W-1:0]  line_count_reg;
    logic [CNT_W-1:0]  ce;

    logic [POS_W-1:0]  len_reg [MAX_LINES];
    logic              len_we;
    logic [POS_W-1:0]  len_wdata;
    logic [POS_W-1:0]  len_rd;

    logic [SLOT_W-1:0] write_slot_reg, write_slot_next;
    logic [POS_W-1:0]  line_pos_reg, line_pos_next;
    logic [POS_W-1:0]  stored_len_reg, stored_len_next;
    logic              zero_seen_reg, zero_seen_next;
    logic [SLOT_W-1:0] read_slot_reg, read_slot_next;
    logic [POS_W-1:0]  read_ofs_reg, read_ofs_next;
    logic [CNT_W-1:0]  slots_done_reg, slots_done_next;
    logic              reading_reg, reading_next;

    logic [7:0]        store_mem [STORE_DEPTH];
    logic [7:0]        mem_q;

    logic              out_valid_reg;
    logic [7:0]        out_byte_reg;
    logic              out_byte_valid_reg;
    logic              out_last_reg;

    logic              pos_live;
    logic              do_store;
    logic [7:0]        store_val;
    logic              wr_en;
    logic              commit_end;
    logic [SLOT_W-1:0] ws_succ;
    logic [SLOT_W-1:0] rs_succ;
    logic [POS_W-1:0]  pos_inc;
    logic [POS_W-1:0]  ofs_inc;
    logic              exhausted;

    assign ce        = count_eff(line_count_reg);
    assign len_rd    = len_reg[read_slot_reg];
    assign exhausted = (slots_done_reg >= ce);
    assign ws_succ   = next_slot(write_slot_reg, ce);
    assign rs_succ   = next_slot(read_slot_reg, ce);
    assign pos_inc   = line_pos_reg + POS_W'(1);
    assign ofs_inc   = read_ofs_reg + POS_W'(1);

    // byte path: past the limit a newline stands in, later bytes are neither stored nor counted
    assign pos_live   = (line_pos_reg <= POS_W'(LINE_MAX));
    assign do_store   = pos_live && !zero_seen_reg;
    assign store_val  = (line_pos_reg == POS_W'(LINE_MAX)) ? NEWLINE_CODE : data_byte;
    assign wr_en      = cmd.byte_wr && do_store && (store_val != 8'd0);
    assign commit_end = cmd.end_in && (line_pos_reg != '0);

    // status to the controller
    assign sts.reading     = reading_reg;
    assign sts.exhausted   = exhausted;
    assign sts.len_zero    = (len_rd == '0);
    assign sts.offset_past = (read_ofs_reg >= len_rd);
    assign sts.out_free    = !out_valid_reg || out_ready;

    // pointer and line state updates
    always_comb
    begin
        write_slot_next = write_slot_reg;
        line_pos_next   = line_pos_reg;
        stored_len_next = stored_len_reg;
        zero_seen_next  = zero_seen_reg;
        read_slot_next  = read_slot_reg;
        read_ofs_next   = read_ofs_reg;
        slots_done_next = slots_done_reg;
        reading_next    = reading_reg;
        len_we          = 1'b0;
        len_wdata       = stored_len_reg;

        if (cmd.byte_wr)
        begin
            if (wr_en)
            begin
                stored_len_next = pos_inc;
            end
            if (do_store && store_val == 8'd0)
            begin
                zero_seen_next = 1'b1;
            end
            if (pos_live)
            begin
                line_pos_next = pos_inc;
            end
            // newline commits the line to its slot
            if (data_byte == NEWLINE_CODE)
            begin
                len_we          = 1'b1;
                len_wdata       = wr_en ? pos_inc : stored_len_reg;
                write_slot_next = ws_succ;
                line_pos_next   = '0;
                stored_len_next = '0;
                zero_seen_next  = 1'b0;
            end
        end

        if (cmd.end_in)
        begin
            if (commit_end)
            begin
                len_we          = 1'b1;
                len_wdata       = stored_len_reg;
                write_slot_next = ws_succ;
                line_pos_next   = '0;
                stored_len_next = '0;
                zero_seen_next  = 1'b0;
            end
            reading_next    = 1'b1;
            read_slot_next  = commit_end ? ws_succ : write_slot_reg;
            read_ofs_next   = '0;
            slots_done_next = '0;
        end

        if (cmd.skip_step)
        begin
            read_slot_next  = rs_succ;
            read_ofs_next   = '0;
            slots_done_next = slots_done_reg + CNT_W'(1);
        end

        // advance past the fetched byte, close the slot at its end
        if (cmd.fetch)
        begin
            if (ofs_inc >= len_rd)
            begin
                read_slot_next  = rs_succ;
                read_ofs_next   = '0;
                slots_done_next = slots_done_reg + CNT_W'(1);
            end
            else
            begin
                read_ofs_next = ofs_inc;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_count_reg <= DEF_LINE_COUNT;
            write_slot_reg <= '0;
            line_pos_reg   <= '0;
            stored_len_reg <= '0;
            zero_seen_reg  <= 1'b0;
            read_slot_reg  <= '0;
            read_ofs_reg   <= '0;
            slots_done_reg <= '0;
            reading_reg    <= 1'b0;
            for (int i = 0; i < MAX_LINES; i++)
            begin
                len_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_valid)
            begin
                line_count_reg <= cfg_data;
            end
            write_slot_reg <= write_slot_next;
            line_pos_reg   <= line_pos_next;
            stored_len_reg <= stored_len_next;
            zero_seen_reg  <= zero_seen_next;
            read_slot_reg  <= read_slot_next;
            read_ofs_reg   <= read_ofs_next;
            slots_done_reg <= slots_done_next;
            reading_reg    <= reading_next;
            if (len_we)
            begin
                len_reg[write_slot_reg] <= len_wdata;
            end
        end
    end

    // line store, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[{write_slot_reg, line_pos_reg[OFS_W-1:0]}] <= store_val;
        end
        if (cmd.fetch)
        begin
            mem_q <= store_mem[{read_slot_reg, read_ofs_reg[OFS_W-1:0]}];
        end
    end

    // output beat valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_null || cmd.load_byte)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output beat payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_null)
        begin
            out_byte_reg       <= 8'd0;
            out_byte_valid_reg <= 1'b0;
            out_last_reg       <= 1'b0;
        end
        else if (cmd.load_byte)
        begin
            out_byte_reg       <= mem_q;
            out_byte_valid_reg <= 1'b1;
            out_last_reg       <= exhausted;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_byte       = out_byte_reg;
    assign out_byte_valid = out_byte_valid_reg;
    assign out_last       = out_last_reg;

    `LLRB_ASSERT_IMP(a_no_fill_in_readout, clk, rst_n, cmd.byte_wr || cmd.end_in, !reading_reg, "fill command during readout")
    `LLRB_ASSERT_NXT(a_readout_sticky, clk, rst_n, reading_reg, reading_reg, "readout mode dropped without reset")
    `LLRB_ASSERT_NXT(a_null_beat, clk, rst_n, cmd.load_null, out_valid_reg && !out_byte_valid_reg && !out_last_reg, "empty result beat malformed")
    `LLRB_ASSERT_IMP(a_load_when_free, clk, rst_n, cmd.load_byte || cmd.load_null, !out_valid_reg || out_ready, "output register overwritten")
    `LLRB_ASSERT_IMP(a_done_bound, clk, rst_n, reading_reg, slots_done_reg <= CNT_W'(MAX_LINES), "slot count past ring size")

endmodule

>>> rtl/last_lines_ring_buffer.sv
// data bytes, ignored and unknown beats: one beat per cycle while the fsm is idle
// end of input: the fsm passes over empty slots before it takes input again
// read: check, then skip of empty slots if past the slot's end, fetch, skip of empty
//   slots after it, load of the byte beat; with no byte left, an empty beat instead;
//   input is blocked until the result is loaded, a stalled output adds its wait
// reset clears slot lengths, pointers and mode at once; the line store is not cleared
module last_lines_ring_buffer
    import llrb_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [7:0]       s_axis_tdata,   // data_byte
    input  logic [1:0]       s_axis_tuser,   // operation
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // out_byte
    output logic             m_axis_tuser,   // byte_valid
    output logic             m_axis_tlast,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CNT_W-1:0] cfg_data        // line_count
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    assign cfg_ready = 1'b1;

    // sequencer
    llrb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .operation (op_t'(s_axis_tuser)),
        .sts       (sts),
        .cmd       (cmd)
    );

    // line store, pointers and output register
    llrb_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .data_byte      (s_axis_tdata),
        .cfg_valid      (cfg_valid),
        .cfg_data       (cfg_data),
        .out_ready      (m_axis_tready),
        .out_valid      (m_axis_tvalid),
        .out_byte       (m_axis_tdata),
        .out_byte_valid (m_axis_tuser),
        .out_last       (m_axis_tlast)
    );

endmodule

>>> dv/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import llrb_pkg::*;

    localparam int SLOT_SPAN    = LINE_MAX + 1;
    localparam int SETTLE_TICKS = 32;
    localparam int STALL_LIMIT  = 4000;

    // one text beat on the slave side
    typedef struct packed {
        op_t        op;
        logic [7:0] ch;
    } text_beat_t;

    // one readout beat on the master side
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       last_byte;
    } readout_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [7:0]       s_axis_tdata = '0;     // data_byte
    logic [1:0]       s_axis_tuser = OP_DATA; // operation
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [7:0]       m_axis_tdata;          // out_byte
    logic             m_axis_tuser;          // byte_valid
    logic             m_axis_tlast;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CNT_W-1:0] cfg_data = '0;         // line_count

    // stimulus and expectations
    text_beat_t send_q[$];
    readout_t   readout_q[$];
    text_beat_t next_beat;
    readout_t   predicted;
    readout_t   want_beat;
    int         send_idle = 27;
    int         recv_idle = 52;
    int         mismatches = 0;
    int         quiet_cycles = 0;

    // mirror of the line ring
    logic [7:0]       line_mem [STORE_DEPTH];
    logic [POS_W-1:0] slot_len [MAX_LINES] = '{default: '0};
    int unsigned      wr_slot = 0;
    int unsigned      line_pos = 0;
    int unsigned      kept_len = 0;
    int unsigned      rd_slot = 0;
    int unsigned      rd_ofs = 0;
    int unsigned      slots_passed = 0;
    bit               zero_hit = 1'b0;
    bit               replay = 1'b0;
    bit               readout_over = 1'b0;
    logic [CNT_W-1:0] ring_cfg = DEF_LINE_COUNT;

    last_lines_ring_buffer u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // ring size actually in use
    function automatic int unsigned ring_size();
        if (ring_cfg == '0)
        begin
            return 1;
        end
        if (ring_cfg > CNT_W'(MAX_LINES))
        begin
            return MAX_LINES;
        end
        return ring_cfg;
    endfunction

    function automatic int unsigned ring_step(input int unsigned s);
        int unsigned n;
        n = s + 1;
        if (n >= ring_size() || n >= MAX_LINES)
        begin
            n = 0;
        end
        return n;
    endfunction

    // commit the line being collected to its slot
    function automatic void close_line();
        slot_len[wr_slot] = POS_W'(kept_len);
        wr_slot  = ring_step(wr_slot);
        line_pos = 0;
        kept_len = 0;
        zero_hit = 1'b0;
    endfunction

    // a zero byte ends what is kept of the line
    function automatic void keep_char(input logic [7:0] b);
        if (zero_hit)
        begin
            return;
        end
        if (b == 8'd0)
        begin
            zero_hit = 1'b1;
            return;
        end
        line_mem[wr_slot * SLOT_SPAN + line_pos] = b;
        kept_len = line_pos + 1;
    endfunction

    function automatic void pass_empty_slots();
        while (slots_passed < ring_size() && slot_len[rd_slot] == '0)
        begin
            rd_slot = ring_step(rd_slot);
            rd_ofs  = 0;
            slots_passed++;
        end
    endfunction

    // apply one text beat to the mirror, returns 1 when a readout beat follows
    function automatic bit tail_accept(input op_t op, input logic [7:0] b,
                                       output readout_t r);
        r = '0;
        case (op)
            OP_DATA:
            begin
                if (!replay)
                begin
                    if (line_pos < LINE_MAX)
                    begin
                        keep_char(b);
                    end
                    else if (line_pos == LINE_MAX)
                    begin
                        keep_char(NEWLINE_CODE);
                    end
                    if (line_pos <= LINE_MAX)
                    begin
                        line_pos++;
                    end
                    if (b == NEWLINE_CODE)
                    begin
                        close_line();
                    end
                end
                return 1'b0;
            end
            OP_END:
            begin
                if (!replay)
                begin
                    if (line_pos > 0)
                    begin
                        close_line();
                    end
                    replay       = 1'b1;
                    rd_slot      = wr_slot;
                    rd_ofs       = 0;
                    slots_passed = 0;
                    pass_empty_slots();
                end
                return 1'b0;
            end
            OP_READ:
            begin
                if (!replay || slots_passed >= ring_size())
                begin
                    return 1'b1;
                end
                if (rd_ofs >= slot_len[rd_slot])
                begin
                    pass_empty_slots();
                    if (slots_passed >= ring_size())
                    begin
                        return 1'b1;
                    end
                end
                r.out_byte   = line_mem[rd_slot * SLOT_SPAN + rd_ofs];
                r.byte_valid = 1'b1;
                rd_ofs++;
                if (rd_ofs >= slot_len[rd_slot])
                begin
                    rd_slot = ring_step(rd_slot);
                    rd_ofs  = 0;
                    slots_passed++;
                    pass_empty_slots();
                end
                r.last_byte = (slots_passed >= ring_size());
                return 1'b1;
            end
            default:
            begin
                return 1'b0;
            end
        endcase
    endfunction

    // slave side driver, predicts each accepted beat
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= OP_DATA;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (tail_accept(op_t'(s_axis_tuser), s_axis_tdata, predicted))
                begin
                    readout_q.push_back(predicted);
                    if (replay && !predicted.byte_valid)
                    begin
                        readout_over = 1'b1;
                    end
                end
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (send_q.size() != 0 && $urandom_range(0, 99) >= send_idle)
                begin
                    next_beat = send_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= next_beat.ch;
                    s_axis_tuser  <= next_beat.op;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // master side back pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    // compare each readout beat with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (readout_q.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected beat, expected none, got byte %h valid %b last %b",
                         $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
            end
            else
            begin
                want_beat = readout_q.pop_front();
                if (want_beat.out_byte !== m_axis_tdata)
                begin
                    mismatches++;
                    $display("%0t: out_byte expected %h got %h",
                             $time, want_beat.out_byte, m_axis_tdata);
                end
                if (want_beat.byte_valid !== m_axis_tuser)
                begin
                    mismatches++;
                    $display("%0t: byte_valid expected %b got %b",
                             $time, want_beat.byte_valid, m_axis_tuser);
                end
                if (want_beat.last_byte !== m_axis_tlast)
                begin
                    mismatches++;
                    $display("%0t: last_byte expected %b got %b",
                             $time, want_beat.last_byte, m_axis_tlast);
                end
            end
        end
    end

    // watchdog on cycles with no handshake anywhere
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (cfg_valid && cfg_ready))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    task automatic queue_beat(input op_t o, input logic [7:0] c);
        text_beat_t t;
        t.op = o;
        t.ch = c;
        send_q.push_back(t);
    endtask

    // mostly printable text, now and then any byte or a zero
    function automatic logic [7:0] pick_char();
        int unsigned k;
        k = $urandom_range(0, 99);
        if (k < 2)
        begin
            return 8'd0;
        end
        if (k < 6)
        begin
            return 8'($urandom_range(0, 255));
        end
        return 8'($urandom_range(32, 126));
    endfunction

    // random line with newline, a read slipped in now and then
    task automatic queue_line(input int unsigned len, inout int unsigned n);
        for (int unsigned i = 0; i < len; i++)
        begin
            queue_beat(OP_DATA, pick_char());
            if ($urandom_range(0, 49) == 0)
            begin
                queue_beat(OP_READ, 8'($urandom_range(0, 255)));
                n++;
            end
        end
        queue_beat(OP_DATA, NEWLINE_CODE);
        n += len + 1;
    endtask

    // wait until every beat is accepted and answered, then let end of input finish
    task automatic settle_block();
        do @(negedge clk);
        while (send_q.size() != 0 || s_axis_tvalid || readout_q.size() != 0);
        repeat (SETTLE_TICKS) @(negedge clk);
    endtask

    task automatic write_line_count(input logic [CNT_W-1:0] v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk);
        while (!cfg_ready);
        ring_cfg = v;
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // reads until the readout runs dry, with ignored beats mixed in
    task automatic drain_readout();
        int unsigned k;
        do
        begin
            repeat (40)
            begin
                k = $urandom_range(0, 99);
                if (k < 90)
                begin
                    queue_beat(OP_READ, 8'($urandom_range(0, 255)));
                end
                else if (k < 95)
                begin
                    queue_beat(OP_DATA, 8'($urandom_range(0, 255)));
                end
                else if (k < 98)
                begin
                    queue_beat(OP_END, 8'($urandom_range(0, 255)));
                end
                else
                begin
                    queue_beat(OP_NONE, 8'($urandom_range(0, 255)));
                end
            end
            settle_block();
        end
        while (!readout_over);
    endtask

    initial
    begin
        logic [CNT_W-1:0] lc_pick [8];
        int unsigned      n;
        int unsigned      k;
        int unsigned      len;

        lc_pick = '{5'd0, 5'd31, 5'd16, 5'd1, 5'd0, 5'd0, 5'd3, 5'd0};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // read while filling, unknown op, extreme bytes, empty line
        queue_beat(OP_READ, 8'hFF);
        queue_beat(OP_NONE, 8'h00);
        queue_beat(OP_DATA, 8'h01);
        queue_beat(OP_DATA, 8'hFF);
        queue_beat(OP_DATA, 8'h80);
        queue_beat(OP_DATA, NEWLINE_CODE);
        queue_beat(OP_DATA, NEWLINE_CODE);
        // zero in mid line and at line start
        queue_beat(OP_DATA, "A");
        queue_beat(OP_DATA, 8'h00);
        queue_beat(OP_DATA, "B");
        queue_beat(OP_DATA, NEWLINE_CODE);
        queue_beat(OP_DATA, 8'h00);
        queue_beat(OP_DATA, "C");
        queue_beat(OP_DATA, NEWLINE_CODE);
        // alternating bit patterns
        queue_beat(OP_DATA, 8'h55);
        queue_beat(OP_DATA, 8'hAA);
        queue_beat(OP_DATA, 8'h7F);
        queue_beat(OP_DATA, NEWLINE_CODE);
        queue_beat(OP_READ, 8'h00);
        queue_beat(OP_NONE, 8'hFF);
        settle_block();

        // random filling phases under several ring sizes
        for (int p = 0; p < 8; p++)
        begin
            if (p == 4)
            begin
                send_idle = 52;
                recv_idle = 27;
            end
            if (lc_pick[p] == 5'd0 && (p == 4 || p == 5 || p == 7))
            begin
                lc_pick[p] = CNT_W'($urandom_range(0, 31));
            end
            write_line_count(lc_pick[p]);
            n = 0;
            while (n < 200)
            begin
                k = $urandom_range(0, 99);
                if (k < 8)
                begin
                    queue_beat(OP_READ, 8'($urandom_range(0, 255)));
                    n++;
                end
                else if (k < 10)
                begin
                    queue_beat(OP_NONE, 8'($urandom_range(0, 255)));
                    n++;
                end
                else
                begin
                    k = $urandom_range(0, 99);
                    if (k < 70)
                    begin
                        len = $urandom_range(0, 20);
                    end
                    else if (k < 95)
                    begin
                        len = $urandom_range(21, 80);
                    end
                    else
                    begin
                        len = $urandom_range(81, 300);
                    end
                    queue_line(len, n);
                end
            end
            settle_block();
        end

        // over-long line, a few short ones, a partial line, then end of input
        send_idle = 0;
        recv_idle = 0;
        write_line_count(5'd12);
        len = $urandom_range(2048, 2100);
        for (int unsigned i = 0; i < len; i++)
        begin
            queue_beat(OP_DATA, 8'($urandom_range(32, 126)));
        end
        queue_beat(OP_DATA, NEWLINE_CODE);
        n = 0;
        repeat (3)
        begin
            queue_line($urandom_range(0, 30), n);
        end
        repeat ($urandom_range(1, 10))
        begin
            queue_beat(OP_DATA, 8'($urandom_range(32, 126)));
        end
        queue_beat(OP_END, 8'($urandom_range(0, 255)));
        drain_readout();

        // growing the ring after the readout ran dry resumes it
        write_line_count(5'd16);
        readout_over = 1'b0;
        drain_readout();
        repeat (4)
        begin
            queue_beat(OP_READ, 8'($urandom_range(0, 255)));
        end
        settle_block();

        if (mismatches == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
